>>> hdl/eapsc_pkg.sv
package eapsc_pkg;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_START     = 3'd1,
        PH_IDENTITY  = 3'd2,
        PH_CHALLENGE = 3'd3,
        PH_SUCCESS   = 3'd4,
        PH_FAILURE   = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        HALT_NONE     = 2'd0,
        HALT_RETRIES  = 2'd1,
        HALT_FAILURES = 2'd2,
        HALT_LOGOFF   = 2'd3
    } t_halt;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_FRAME = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    localparam logic [1:0] SEND_NONE     = 2'd0;
    localparam logic [1:0] SEND_START    = 2'd1;
    localparam logic [1:0] SEND_IDENTITY = 2'd2;
    localparam logic [1:0] SEND_MD5      = 2'd3;

    localparam logic [7:0] EAPOL_EAP_PACKET = 8'd0;
    localparam logic [7:0] CODE_REQUEST     = 8'd1;
    localparam logic [7:0] CODE_SUCCESS     = 8'd3;
    localparam logic [7:0] CODE_FAILURE     = 8'd4;
    localparam logic [7:0] KIND_IDENTITY    = 8'd1;
    localparam logic [7:0] KIND_MD5         = 8'd4;

    localparam logic [47:0] GROUP_ADDR = 48'h0180_C200_0003;

    localparam logic [2:0] REG_RETRY_LIMIT    = 3'd0;
    localparam logic [2:0] REG_FAIL_LIMIT     = 3'd1;
    localparam logic [2:0] REG_AUTH_ROUNDS    = 3'd2;
    localparam logic [2:0] REG_STAGE_TICKS    = 3'd3;
    localparam logic [2:0] REG_FAIL_WAIT      = 3'd4;
    localparam logic [2:0] REG_LOGOFF_RESTART = 3'd5;

    typedef struct packed {
        logic [7:0]  retry_limit;
        logic [7:0]  fail_limit;
        logic [3:0]  auth_rounds;
        logic [15:0] stage_ticks;
        logic [15:0] fail_wait;
        logic        logoff_restart;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  reentry;
        logic [3:0]  round;
        logic [7:0]  fails;
        logic [47:0] server;
        logic [7:0]  last_id;
        logic [16:0] watchdog;
        logic [16:0] restart;
        t_halt       halt;
    } t_state;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  eapol_kind;
        logic [7:0]  msg_code;
        logic [7:0]  eap_kind;
        logic [7:0]  eap_id;
        logic [47:0] source_mac;
    } t_item;

    typedef struct packed {
        logic [1:0]  send_kind;
        logic [7:0]  resp_id;
        logic [47:0] dest_mac;
        t_phase      phase;
        logic [3:0]  round_now;
        t_halt       halt_code;
    } t_result;

endpackage

>>> hdl/eapsc_step.sv
// Next-state and result logic for one item.
module eapsc_step (
    input  eapsc_pkg::t_state  i_state,
    input  eapsc_pkg::t_cfg    i_cfg,
    input  eapsc_pkg::t_item   i_item,
    output eapsc_pkg::t_state  o_state,
    output eapsc_pkg::t_result o_result
);

    typedef struct packed {
        eapsc_pkg::t_state st;
        logic [1:0]        kind;
        logic [7:0]        id;
    } t_enter;

    function automatic eapsc_pkg::t_state session_clear(eapsc_pkg::t_state s);
        eapsc_pkg::t_state r;
        r          = s;
        r.watchdog = '0;
        r.reentry  = '0;
        r.phase    = eapsc_pkg::PH_IDLE;
        r.round    = 4'd1;
        r.fails    = '0;
        r.server   = eapsc_pkg::GROUP_ADDR;
        return r;
    endfunction

    function automatic t_enter enter_phase(eapsc_pkg::t_state s, eapsc_pkg::t_cfg c,
                                           eapsc_pkg::t_phase target, logic [7:0] id);
        t_enter e;
        logic   go;
        e.st   = s;
        e.kind = eapsc_pkg::SEND_NONE;
        e.id   = '0;
        go     = (s.halt == eapsc_pkg::HALT_NONE);
        if (go) begin
            if (s.phase == target) begin
                if (e.st.reentry != 8'hFF) e.st.reentry = e.st.reentry + 8'd1;
                if (e.st.reentry >= c.retry_limit) begin
                    e.st.halt = eapsc_pkg::HALT_RETRIES;
                    go        = 1'b0;
                end
            end else begin
                e.st.reentry  = '0;
                e.st.watchdog = {1'b0, c.stage_ticks} + 17'd1;
            end
        end
        if (go) begin
            case (target)
                eapsc_pkg::PH_START: begin
                    e.kind     = eapsc_pkg::SEND_START;
                    e.st.phase = eapsc_pkg::PH_START;
                end
                eapsc_pkg::PH_IDENTITY: begin
                    e.kind     = eapsc_pkg::SEND_IDENTITY;
                    e.id       = id;
                    e.st.phase = eapsc_pkg::PH_IDENTITY;
                end
                eapsc_pkg::PH_CHALLENGE: begin
                    e.kind     = eapsc_pkg::SEND_MD5;
                    e.id       = id;
                    e.st.phase = eapsc_pkg::PH_CHALLENGE;
                end
                eapsc_pkg::PH_SUCCESS: begin
                    e.st.watchdog = '0;
                    if (e.st.round >= c.auth_rounds) begin
                        e.st       = session_clear(e.st);
                        e.st.phase = eapsc_pkg::PH_SUCCESS;
                    end else begin
                        // intermediate round: go straight back to start
                        e.st.fails    = '0;
                        e.st.round    = e.st.round + 4'd1;
                        e.st.reentry  = '0;
                        e.st.watchdog = {1'b0, c.stage_ticks} + 17'd1;
                        e.kind        = eapsc_pkg::SEND_START;
                        e.st.phase    = eapsc_pkg::PH_START;
                    end
                end
                eapsc_pkg::PH_FAILURE: begin
                    e.st.watchdog = '0;
                    if (e.st.phase == eapsc_pkg::PH_SUCCESS) begin
                        // logoff after a finished session
                        if (c.logoff_restart) begin
                            e.st.restart = 17'd2;
                            e.st.phase   = eapsc_pkg::PH_FAILURE;
                        end else begin
                            e.st.halt = eapsc_pkg::HALT_LOGOFF;
                        end
                    end else begin
                        if (e.st.fails != 8'hFF) e.st.fails = e.st.fails + 8'd1;
                        if (e.st.fails >= c.fail_limit) begin
                            e.st.halt = eapsc_pkg::HALT_FAILURES;
                        end else begin
                            e.st.restart = {1'b0, c.fail_wait} + 17'd1;
                            e.st.phase   = eapsc_pkg::PH_FAILURE;
                        end
                    end
                end
                default: ;
            endcase
        end
        return e;
    endfunction

    t_enter            w_e;
    eapsc_pkg::t_state w_s;
    logic              w_restart_due;
    logic              w_dog_due;
    logic              w_dog_phase;

    always_comb begin
        w_e.st        = i_state;
        w_e.kind      = eapsc_pkg::SEND_NONE;
        w_e.id        = '0;
        w_s           = i_state;
        w_restart_due = 1'b0;
        w_dog_due     = 1'b0;
        w_dog_phase   = 1'b0;
        if (i_state.halt == eapsc_pkg::HALT_NONE) begin
            case (i_item.req_type)
                eapsc_pkg::REQ_START: begin
                    w_e = enter_phase(i_state, i_cfg, eapsc_pkg::PH_START, 8'd0);
                end
                eapsc_pkg::REQ_FRAME: begin
                    w_s.last_id = i_item.eap_id;
                    w_e.st      = w_s;
                    if (i_item.eapol_kind == eapsc_pkg::EAPOL_EAP_PACKET) begin
                        case (i_item.msg_code)
                            eapsc_pkg::CODE_REQUEST: begin
                                w_s.server = i_item.source_mac;
                                w_e.st     = w_s;
                                if (i_item.eap_kind == eapsc_pkg::KIND_IDENTITY) begin
                                    w_e = enter_phase(w_s, i_cfg, eapsc_pkg::PH_IDENTITY,
                                                      i_item.eap_id);
                                end else if (i_item.eap_kind == eapsc_pkg::KIND_MD5) begin
                                    w_e = enter_phase(w_s, i_cfg, eapsc_pkg::PH_CHALLENGE,
                                                      i_item.eap_id);
                                end
                            end
                            eapsc_pkg::CODE_SUCCESS: begin
                                w_e = enter_phase(w_s, i_cfg, eapsc_pkg::PH_SUCCESS,
                                                  i_item.eap_id);
                            end
                            eapsc_pkg::CODE_FAILURE: begin
                                w_e = enter_phase(w_s, i_cfg, eapsc_pkg::PH_FAILURE,
                                                  i_item.eap_id);
                            end
                            default: ;
                        endcase
                    end
                end
                eapsc_pkg::REQ_TICK: begin
                    if (w_s.restart != '0) begin
                        w_s.restart = w_s.restart - 17'd1;
                        if (w_s.restart <= 17'd1) begin
                            w_s.restart   = '0;
                            w_restart_due = 1'b1;
                        end
                    end
                    if (w_s.watchdog != '0) begin
                        w_s.watchdog = w_s.watchdog - 17'd1;
                        if (w_s.watchdog <= 17'd1) begin
                            w_s.watchdog = '0;
                            w_dog_due    = 1'b1;
                        end
                    end
                    w_dog_phase = (w_s.phase == eapsc_pkg::PH_START)
                               || (w_s.phase == eapsc_pkg::PH_IDENTITY)
                               || (w_s.phase == eapsc_pkg::PH_CHALLENGE);
                    w_e.st = w_s;
                    if (w_restart_due) begin
                        w_e = enter_phase(session_clear(w_s), i_cfg, eapsc_pkg::PH_START,
                                          8'd0);
                    end else if (w_dog_due && w_dog_phase) begin
                        w_e = enter_phase(w_s, i_cfg, w_s.phase, w_s.last_id);
                        if (w_e.st.halt == eapsc_pkg::HALT_NONE) begin
                            w_e.st.watchdog = {1'b0, i_cfg.stage_ticks} + 17'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_state = w_e.st;
        if (w_e.st.halt != eapsc_pkg::HALT_NONE) begin
            o_result.send_kind = eapsc_pkg::SEND_NONE;
            o_result.resp_id   = '0;
        end else begin
            o_result.send_kind = w_e.kind;
            o_result.resp_id   = w_e.id;
        end
        o_result.dest_mac  = (o_result.send_kind != eapsc_pkg::SEND_NONE) ? w_e.st.server : '0;
        o_result.phase     = w_e.st.phase;
        o_result.round_now = w_e.st.round;
        o_result.halt_code = w_e.st.halt;
    end

endmodule

>>> hdl/eapol_supplicant_controller_core.sv
// Channel   Dir  Handshake                       Payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tuser req_type, tdata frame summary
// m_axis    out  m_axis_tvalid / m_axis_tready   tuser send_kind, tdata status
// apb       in   psel & penable & pwrite         six config registers at 4*i
//
// One item per cycle sustained while the output is not stalled. An item waits in
// the input register, is decided by the step logic and lands in the output register;
// the result is valid once the output register holds it and transfers out when
// m_axis_tready is high.
// Synchronous active-low reset: session state back to idle, round 1, group
// address, both countdowns disarmed, config registers to defaults.
// A stalled output holds its result; the input register keeps taking items
// as long as the output register drains or is empty.
module eapol_supplicant_controller_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // receive side
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [1:0]   s_axis_tuser,  // [1:0] req_type
    input  logic [79:0]  s_axis_tdata,  // eapol_kind, msg_code, eap_kind, eap_id, source_mac
    // send side
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [1:0]   m_axis_tuser,  // [1:0] send_kind
    output logic [71:0]  m_axis_tdata,  // resp_id, dest_mac, phase, round_now, halt_code, pad
    // config
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    eapsc_pkg::t_cfg    r_cfg;
    eapsc_pkg::t_state  r_state;
    eapsc_pkg::t_state  n_state;
    eapsc_pkg::t_item   r_item;
    eapsc_pkg::t_result n_result;
    eapsc_pkg::t_result r_result;
    logic               r_in_valid;
    logic               r_out_valid;
    logic               w_advance;
    logic               w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.retry_limit    <= 8'd3;
            r_cfg.fail_limit     <= 8'd3;
            r_cfg.auth_rounds    <= 4'd1;
            r_cfg.stage_ticks    <= 16'd5;
            r_cfg.fail_wait      <= 16'd15;
            r_cfg.logoff_restart <= 1'b1;
        end else if (w_cfg_wr) begin
            case (paddr[4:2])
                eapsc_pkg::REG_RETRY_LIMIT:    r_cfg.retry_limit    <= pwdata[7:0];
                eapsc_pkg::REG_FAIL_LIMIT:     r_cfg.fail_limit     <= pwdata[7:0];
                eapsc_pkg::REG_AUTH_ROUNDS:    r_cfg.auth_rounds    <= pwdata[3:0];
                eapsc_pkg::REG_STAGE_TICKS:    r_cfg.stage_ticks    <= pwdata[15:0];
                eapsc_pkg::REG_FAIL_WAIT:      r_cfg.fail_wait      <= pwdata[15:0];
                eapsc_pkg::REG_LOGOFF_RESTART: r_cfg.logoff_restart <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            eapsc_pkg::REG_RETRY_LIMIT:    prdata = {24'd0, r_cfg.retry_limit};
            eapsc_pkg::REG_FAIL_LIMIT:     prdata = {24'd0, r_cfg.fail_limit};
            eapsc_pkg::REG_AUTH_ROUNDS:    prdata = {28'd0, r_cfg.auth_rounds};
            eapsc_pkg::REG_STAGE_TICKS:    prdata = {16'd0, r_cfg.stage_ticks};
            eapsc_pkg::REG_FAIL_WAIT:      prdata = {16'd0, r_cfg.fail_wait};
            eapsc_pkg::REG_LOGOFF_RESTART: prdata = {31'd0, r_cfg.logoff_restart};
            default:                       prdata = '0;
        endcase
    end

    // item moves on when the output register is free or being drained
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item.req_type   <= s_axis_tuser;
            r_item.eapol_kind <= s_axis_tdata[7:0];
            r_item.msg_code   <= s_axis_tdata[15:8];
            r_item.eap_kind   <= s_axis_tdata[23:16];
            r_item.eap_id     <= s_axis_tdata[31:24];
            r_item.source_mac <= s_axis_tdata[79:32];
        end
    end

    eapsc_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // session state commits together with the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase    <= eapsc_pkg::PH_IDLE;
            r_state.reentry  <= '0;
            r_state.round    <= 4'd1;
            r_state.fails    <= '0;
            r_state.server   <= eapsc_pkg::GROUP_ADDR;
            r_state.last_id  <= '0;
            r_state.watchdog <= '0;
            r_state.restart  <= '0;
            r_state.halt     <= eapsc_pkg::HALT_NONE;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_result.send_kind;
    assign m_axis_tdata  = {7'd0, r_result.halt_code, r_result.round_now, r_result.phase,
                            r_result.dest_mac, r_result.resp_id};

endmodule

>>> hdl/eapsc_checker.sv
module eapsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [1:0]  m_axis_tuser,
    input logic [71:0] m_axis_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // nothing sent: no destination, no id
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == eapsc_pkg::SEND_NONE |->
            m_axis_tdata[55:0] == '0)
        else $error("idle result carries address or id");

    // start frames carry no EAP id
    a_start_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == eapsc_pkg::SEND_START |-> m_axis_tdata[7:0] == '0)
        else $error("start frame with nonzero id");

    // halted block sends nothing
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[64:63] != eapsc_pkg::HALT_NONE |->
            m_axis_tuser == eapsc_pkg::SEND_NONE)
        else $error("send while halted");

    // round counter never reads zero
    a_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[62:59] != 4'd0)
        else $error("round zero");

endmodule

bind eapol_supplicant_controller_core eapsc_checker u_eapsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
);
